@@ hw/rtl/tpfn_pkg.sv @@
// shared constants, widths and beat types for the two-point frame normalizer
// no dependencies; every block file refers to this package by scoped names

package tpfn_pkg;

	// field widths
	localparam int COORD_WIDTH   = 32;
	localparam int OUT_FRAC_BITS = 24;
	localparam int OUT_WIDTH     = 32;
	localparam int TAG_WIDTH     = 16;
	localparam int COORD_FRAC    = COORD_WIDTH - 4;

	// datapath widths
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int D_W    = PROD_W;
	localparam int MAG_W  = PROD_W;

	// divider geometry: quotient of mag * 2^EXTRA / d, QW bits before overflow
	localparam int EXTRA   = OUT_FRAC_BITS + 1;
	localparam int QW      = OUT_WIDTH + 1;
	localparam int QW_INC  = QW + 1;
	localparam int NUM_W   = MAG_W + EXTRA;
	localparam int TOP_W   = NUM_W - QW;
	localparam int CMP_W   = (TOP_W > D_W) ? TOP_W : D_W;

	// output clip limits on the rounded magnitude
	localparam logic [QW-1:0] OUT_PMAX = QW'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);
	localparam logic [QW-1:0] OUT_NMAX = QW'(64'd1 << (OUT_WIDTH - 1));

	// squared length at or below this marks a degenerate frame
	localparam logic [127:0] DEGEN_SCALE = 128'd1 << (2 * COORD_FRAC);
	localparam logic [D_W-1:0] DEGEN_LIMIT =
		D_W'(DEGEN_SCALE / 128'd1000000000000000000);

	// register port geometry
	localparam int APB_DW    = (COORD_WIDTH > 32) ? 64 : 32;
	localparam int REG_SHIFT = (COORD_WIDTH > 32) ? 3 : 2;
	localparam int REG_IDX_W = 2;
	localparam int ADDR_W    = REG_SHIFT + REG_IDX_W;

	localparam logic [COORD_WIDTH-1:0] END_X_RESET = COORD_WIDTH'(64'd1 << COORD_FRAC);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_END_X    = 2'd2,
		REG_END_Y    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] origin_x;
		logic signed [COORD_WIDTH-1:0] origin_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic [TAG_WIDTH-1:0]          point_tag;
	} point_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] norm_x;
		logic signed [OUT_WIDTH-1:0] norm_y;
		logic [TAG_WIDTH-1:0]        result_tag;
		logic                        degenerate;
		logic                        saturated;
	} result_t;

	// one coordinate in flight through the divider
	typedef struct packed {
		logic           neg;
		logic           ovf;
		logic [D_W-1:0] rem;
		logic [QW-1:0]  low;
	} lane_t;

	typedef struct packed {
		lane_t                x;
		lane_t                y;
		logic [D_W-1:0]       d;
		logic                 degen;
		logic [TAG_WIDTH-1:0] tag;
	} quo_item_t;

endpackage

@@ hw/rtl/tpfn_cfg.sv @@
// register file for origin and end point, written over the register port
// depends on tpfn_pkg

module tpfn_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpfn_pkg::ADDR_W-1:0]   paddr,
	input  logic [tpfn_pkg::APB_DW-1:0]   pwdata,
	output logic [tpfn_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output tpfn_pkg::cfg_t                cfg
);

	tpfn_pkg::cfg_t                  cfg_q;
	tpfn_pkg::reg_idx_t              idx;
	logic                            wr_en;
	logic [tpfn_pkg::COORD_WIDTH-1:0] wdata;

	assign idx    = tpfn_pkg::reg_idx_t'(paddr[tpfn_pkg::ADDR_W-1:tpfn_pkg::REG_SHIFT]);
	assign wr_en  = psel && penable && pwrite;
	assign wdata  = pwdata[tpfn_pkg::COORD_WIDTH-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.end_x    <= tpfn_pkg::END_X_RESET;
			cfg_q.end_y    <= '0;
		end else if (wr_en) begin
			case (idx)
				tpfn_pkg::REG_ORIGIN_X: cfg_q.origin_x <= wdata;
				tpfn_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= wdata;
				tpfn_pkg::REG_END_X:    cfg_q.end_x    <= wdata;
				tpfn_pkg::REG_END_Y:    cfg_q.end_y    <= wdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			tpfn_pkg::REG_ORIGIN_X: prdata = tpfn_pkg::APB_DW'($unsigned(cfg_q.origin_x));
			tpfn_pkg::REG_ORIGIN_Y: prdata = tpfn_pkg::APB_DW'($unsigned(cfg_q.origin_y));
			tpfn_pkg::REG_END_X:    prdata = tpfn_pkg::APB_DW'($unsigned(cfg_q.end_x));
			tpfn_pkg::REG_END_Y:    prdata = tpfn_pkg::APB_DW'($unsigned(cfg_q.end_y));
			default:                prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/tpfn_front.sv @@
// front pipeline: offsets, products, dot sums, magnitudes and divider setup
// five register stages; depends on tpfn_pkg

module tpfn_front (
	input  logic                clk,
	input  logic                arst_n,
	input  tpfn_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  tpfn_pkg::point_t    point,
	output logic                out_valid,
	input  logic                out_stall,
	output tpfn_pkg::quo_item_t item
);

	localparam int NS = 5;

	// set up one lane: top of the scaled dividend is the first remainder
	function automatic tpfn_pkg::lane_t prep_lane(
		input logic                       neg,
		input logic [tpfn_pkg::MAG_W-1:0] mag,
		input logic [tpfn_pkg::D_W-1:0]   d
	);
		logic [tpfn_pkg::NUM_W-1:0] num;
		logic [tpfn_pkg::TOP_W-1:0] top;
		tpfn_pkg::lane_t            l;
		num   = {mag, {tpfn_pkg::EXTRA{1'b0}}};
		top   = num[tpfn_pkg::NUM_W-1:tpfn_pkg::QW];
		l.neg = neg;
		l.ovf = (tpfn_pkg::CMP_W'(top) >= tpfn_pkg::CMP_W'(d));
		l.rem = tpfn_pkg::D_W'(top);
		l.low = num[tpfn_pkg::QW-1:0];
		return l;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [NS-1:0] vld;
	logic [NS-1:0] adv;

	logic signed [tpfn_pkg::DIFF_W-1:0] tx_s1, ty_s1, ux_s1, uy_s1;
	logic [tpfn_pkg::TAG_WIDTH-1:0]     tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [tpfn_pkg::PROD_W-1:0] pxx_s2, pyy_s2, pxy_s2, pyx_s2, pdx_s2, pdy_s2;
	logic signed [tpfn_pkg::SUM_W-1:0]  nx_s3, ny_s3;
	logic [tpfn_pkg::D_W-1:0]           d_s3, d_s4;
	logic [tpfn_pkg::MAG_W-1:0]         mag_x_s4, mag_y_s4;
	logic                               neg_x_s4, neg_y_s4, degen_s4;
	tpfn_pkg::quo_item_t                item_s5;

	// a stage moves unless it and everything after it is full and stalled
	assign vld = {v_s5, v_s4, v_s3, v_s2, v_s1};
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = !(out_stall && (&vld[NS-1:k]));
	end

	assign in_stall  = !adv[0];
	assign out_valid = v_s5;
	assign item      = item_s5;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv[0]) v_s1 <= in_valid;
			if (adv[1]) v_s2 <= v_s1;
			if (adv[2]) v_s3 <= v_s2;
			if (adv[3]) v_s4 <= v_s3;
			if (adv[4]) v_s5 <= v_s4;
		end
	end

	// stage 1: offsets from the origin
	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) begin
			tx_s1  <= tpfn_pkg::DIFF_W'(point.point_x) - tpfn_pkg::DIFF_W'(cfg.origin_x);
			ty_s1  <= tpfn_pkg::DIFF_W'(point.point_y) - tpfn_pkg::DIFF_W'(cfg.origin_y);
			ux_s1  <= tpfn_pkg::DIFF_W'(cfg.end_x) - tpfn_pkg::DIFF_W'(cfg.origin_x);
			uy_s1  <= tpfn_pkg::DIFF_W'(cfg.end_y) - tpfn_pkg::DIFF_W'(cfg.origin_y);
			tag_s1 <= point.point_tag;
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (adv[1] && v_s1) begin
			pxx_s2 <= tx_s1 * ux_s1;
			pyy_s2 <= ty_s1 * uy_s1;
			pxy_s2 <= tx_s1 * uy_s1;
			pyx_s2 <= ty_s1 * ux_s1;
			pdx_s2 <= ux_s1 * ux_s1;
			pdy_s2 <= uy_s1 * uy_s1;
			tag_s2 <= tag_s1;
		end
	end

	// stage 3: dot products and squared length
	always_ff @(posedge clk) begin
		if (adv[2] && v_s2) begin
			nx_s3  <= tpfn_pkg::SUM_W'(pxx_s2) + tpfn_pkg::SUM_W'(pyy_s2);
			ny_s3  <= tpfn_pkg::SUM_W'(pyx_s2) - tpfn_pkg::SUM_W'(pxy_s2);
			d_s3   <= tpfn_pkg::D_W'($unsigned(pdx_s2)) + tpfn_pkg::D_W'($unsigned(pdy_s2));
			tag_s3 <= tag_s2;
		end
	end

	// stage 4: sign and magnitude, degenerate check
	always_ff @(posedge clk) begin
		if (adv[3] && v_s3) begin
			neg_x_s4 <= nx_s3[tpfn_pkg::SUM_W-1];
			neg_y_s4 <= ny_s3[tpfn_pkg::SUM_W-1];
			mag_x_s4 <= nx_s3[tpfn_pkg::SUM_W-1] ? tpfn_pkg::MAG_W'(-nx_s3)
			                                     : tpfn_pkg::MAG_W'(nx_s3);
			mag_y_s4 <= ny_s3[tpfn_pkg::SUM_W-1] ? tpfn_pkg::MAG_W'(-ny_s3)
			                                     : tpfn_pkg::MAG_W'(ny_s3);
			degen_s4 <= (d_s3 <= tpfn_pkg::DEGEN_LIMIT);
			d_s4     <= d_s3;
			tag_s4   <= tag_s3;
		end
	end

	// stage 5: overflow pre-check and first remainder
	always_ff @(posedge clk) begin
		if (adv[4] && v_s4) begin
			item_s5.x     <= prep_lane(neg_x_s4, mag_x_s4, d_s4);
			item_s5.y     <= prep_lane(neg_y_s4, mag_y_s4, d_s4);
			item_s5.d     <= d_s4;
			item_s5.degen <= degen_s4;
			item_s5.tag   <= tag_s4;
		end
	end

endmodule

@@ hw/rtl/tpfn_divider.sv @@
// pipelined restoring divider, one quotient bit per stage for both lanes
// depends on tpfn_pkg

module tpfn_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tpfn_pkg::quo_item_t item_in,
	output logic                out_valid,
	input  logic                out_stall,
	output tpfn_pkg::quo_item_t item_out
);

	localparam int NS = tpfn_pkg::QW;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic tpfn_pkg::lane_t div_step(
		input tpfn_pkg::lane_t          l,
		input logic [tpfn_pkg::D_W-1:0] d
	);
		logic [tpfn_pkg::D_W:0]   trial;
		logic [tpfn_pkg::D_W+1:0] diff;
		logic                     fits;
		tpfn_pkg::lane_t          r;
		trial = {l.rem, l.low[tpfn_pkg::QW-1]};
		diff  = {1'b0, trial} - {2'b00, d};
		fits  = !diff[tpfn_pkg::D_W+1];
		r     = l;
		r.rem = fits ? diff[tpfn_pkg::D_W-1:0] : trial[tpfn_pkg::D_W-1:0];
		r.low = {l.low[tpfn_pkg::QW-2:0], fits};
		return r;
	endfunction

	function automatic tpfn_pkg::quo_item_t step_item(input tpfn_pkg::quo_item_t it);
		tpfn_pkg::quo_item_t r;
		r   = it;
		r.x = div_step(it.x, it.d);
		r.y = div_step(it.y, it.d);
		return r;
	endfunction

	tpfn_pkg::quo_item_t div_s [NS];
	tpfn_pkg::quo_item_t nxt   [NS];
	logic [NS-1:0]       vld_s;
	logic [NS-1:0]       src_v;
	logic [NS-1:0]       adv;

	assign src_v = {vld_s[NS-2:0], in_valid};

	// stall chain and next values of each stage
	for (genvar k = 0; k < NS; k++) begin : g_stage
		assign adv[k] = !(out_stall && (&vld_s[NS-1:k]));
		if (k == 0) begin : g_first
			assign nxt[k] = step_item(item_in);
		end else begin : g_next
			assign nxt[k] = step_item(div_s[k-1]);
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_s[NS-1];
	assign item_out  = div_s[NS-1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_s[k] <= src_v[k];
			end
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (adv[k] && src_v[k]) div_s[k] <= nxt[k];
		end
	end

endmodule

@@ hw/rtl/tpfn_round.sv @@
// rounding, sign restore and clipping into the output register
// depends on tpfn_pkg

module tpfn_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tpfn_pkg::quo_item_t item,
	output logic                out_valid,
	input  logic                out_stall,
	output tpfn_pkg::result_t   result
);

	// returns {clipped, value}; quotient carries one extra bit for rounding
	function automatic logic [tpfn_pkg::OUT_WIDTH:0] finish(input tpfn_pkg::lane_t l);
		logic [tpfn_pkg::QW_INC-1:0] inc;
		logic [tpfn_pkg::QW-1:0]     mag;
		logic                        sat;
		logic [tpfn_pkg::QW-1:0]     val;
		inc = {1'b0, l.low} + tpfn_pkg::QW_INC'(1);
		mag = inc[tpfn_pkg::QW_INC-1:1];
		sat = 1'b0;
		if (!l.neg) begin
			if (l.ovf || (mag > tpfn_pkg::OUT_PMAX)) begin
				sat = 1'b1;
				mag = tpfn_pkg::OUT_PMAX;
			end
			val = mag;
		end else begin
			if (l.ovf || (mag > tpfn_pkg::OUT_NMAX)) begin
				sat = 1'b1;
				mag = tpfn_pkg::OUT_NMAX;
			end
			val = -mag;
		end
		return {sat, val[tpfn_pkg::OUT_WIDTH-1:0]};
	endfunction

	logic                          v_s1;
	logic                          adv;
	logic [tpfn_pkg::OUT_WIDTH:0]  fx, fy;
	tpfn_pkg::result_t             res_s1;

	assign adv       = !(v_s1 && out_stall);
	assign in_stall  = !adv;
	assign out_valid = v_s1;
	assign result    = res_s1;

	assign fx = finish(item.x);
	assign fy = finish(item.y);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	// output beat; a degenerate frame gives zeros and no clip flag
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			res_s1.result_tag <= item.tag;
			res_s1.degenerate <= item.degen;
			if (item.degen) begin
				res_s1.norm_x    <= '0;
				res_s1.norm_y    <= '0;
				res_s1.saturated <= 1'b0;
			end else begin
				res_s1.norm_x    <= fx[tpfn_pkg::OUT_WIDTH-1:0];
				res_s1.norm_y    <= fy[tpfn_pkg::OUT_WIDTH-1:0];
				res_s1.saturated <= fx[tpfn_pkg::OUT_WIDTH] | fy[tpfn_pkg::OUT_WIDTH];
			end
		end
	end

endmodule

@@ hw/rtl/two_point_frame_normalizer.sv @@
// Two-point frame normalizer top level, built on tpfn_pkg, tpfn_cfg, tpfn_front,
// tpfn_divider and tpfn_round. Each point beat (signed Q4.28) is mapped into the
// frame where the configured origin lands on (0,0) and the end point on (1,0);
// results are signed Q8.24, rounded to nearest with ties away from zero, clipped
// with a flag, and zero with the degenerate flag when origin and end coincide.
// One point is taken every cycle while point_stall is low; a point passes 39 register
// stages, five front stages (offsets, six 33x33 products, dot sums, magnitudes,
// overflow pre-check), 33 restoring-division stages (one quotient bit each, both
// coordinates side by side) and one rounding stage that is the output register.
// Stalls hold a full stage only while every stage after it is full too; empty stages
// keep filling, so input is still taken while a finished result waits. Registers sit
// at byte addresses 0, 4, 8, 12 (origin x, origin y, end x, end y) and the user must
// see that they are written only while the block is idle; the block does not enforce it.

module two_point_frame_normalizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpfn_pkg::ADDR_W-1:0] paddr,
	input  logic [tpfn_pkg::APB_DW-1:0] pwdata,
	output logic [tpfn_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        point_valid,
	output logic                        point_stall,
	input  tpfn_pkg::point_t            point,
	output logic                        result_valid,
	input  logic                        result_stall,
	output tpfn_pkg::result_t           result
);

	tpfn_pkg::cfg_t      cfg;
	tpfn_pkg::quo_item_t front_item, div_item;
	logic                front_valid, front_stall;
	logic                div_valid, div_stall;

	// configuration registers
	tpfn_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// offsets, products and divider setup
	tpfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (point_valid),
		.in_stall  (point_stall),
		.point     (point),
		.out_valid (front_valid),
		.out_stall (front_stall),
		.item      (front_item)
	);

	// quotient bits
	tpfn_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_stall  (front_stall),
		.item_in   (front_item),
		.out_valid (div_valid),
		.out_stall (div_stall),
		.item_out  (div_item)
	);

	// rounding, clipping and output beat
	tpfn_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_stall  (div_stall),
		.item      (div_item),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.result    (result)
	);

endmodule

@@ tb/sv/tpfn_checker.sv @@
// checker for the two-point frame normalizer: snoops the register port and both
// beat channels, predicts each result from its own frame copy and compares it
// depends on tpfn_pkg for the beat structs, register indexes and widths
`timescale 1ns / 100ps

module tpfn_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpfn_pkg::ADDR_W-1:0] paddr,
	input  logic [tpfn_pkg::APB_DW-1:0] pwdata,
	input  logic                        pready,
	input  logic                        point_valid,
	input  logic                        point_stall,
	input  tpfn_pkg::point_t            point,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  tpfn_pkg::result_t           result,
	output int unsigned                 errors,
	output int unsigned                 pending,
	output int unsigned                 n_degen,
	output int unsigned                 n_clipped
);

	localparam int OW = tpfn_pkg::OUT_WIDTH;
	localparam int CW = tpfn_pkg::COORD_WIDTH;
	localparam logic [127:0] POS_LIMIT = (128'd1 << (OW - 1)) - 128'd1;
	localparam logic [127:0] NEG_LIMIT = 128'd1 << (OW - 1);
	// squared length at or below 1e-18 in squared coordinate units
	localparam logic [127:0] DEGEN_BOUND =
		(128'd1 << (2 * (CW - 4))) / 128'd1000000000000000000;

	tpfn_pkg::cfg_t      frame;
	tpfn_pkg::result_t   awaited[$];
	tpfn_pkg::result_t   want;
	tpfn_pkg::reg_idx_t  widx;

	// divide, round half away from zero, clip to the output range
	function automatic logic [OW-1:0] to_fixed(input logic signed [127:0] num,
			input logic [127:0] dsq, output logic clip);
		logic [127:0] mag, quo, rnd;
		mag = (num < 0) ? -num : num;
		quo = (mag << (tpfn_pkg::OUT_FRAC_BITS + 1)) / dsq;
		rnd = (quo + 128'd1) >> 1;
		clip = 1'b0;
		if (num >= 0) begin
			if (rnd > POS_LIMIT) begin
				clip = 1'b1;
				rnd = POS_LIMIT;
			end
			return rnd[OW-1:0];
		end
		if (rnd > NEG_LIMIT) begin
			clip = 1'b1;
			rnd = NEG_LIMIT;
		end
		rnd = -rnd;
		return rnd[OW-1:0];
	endfunction

	// project p - origin onto u and its +90 degree rotation, over |u|^2
	function automatic tpfn_pkg::result_t map_point(input tpfn_pkg::cfg_t f,
			input tpfn_pkg::point_t p);
		logic signed [127:0] ax, ay, ux, uy, tx, ty;
		logic [127:0] dsq;
		logic clip_x, clip_y;
		tpfn_pkg::result_t r;
		ax = 128'(f.origin_x);
		ay = 128'(f.origin_y);
		ux = 128'(f.end_x) - ax;
		uy = 128'(f.end_y) - ay;
		tx = 128'(p.point_x) - ax;
		ty = 128'(p.point_y) - ay;
		dsq = ux * ux + uy * uy;
		r.result_tag = p.point_tag;
		if (dsq <= DEGEN_BOUND) begin
			r.norm_x = '0;
			r.norm_y = '0;
			r.degenerate = 1'b1;
			r.saturated = 1'b0;
			return r;
		end
		r.norm_x = to_fixed(tx * ux + ty * uy, dsq, clip_x);
		r.norm_y = to_fixed(ty * ux - tx * uy, dsq, clip_y);
		r.degenerate = 1'b0;
		r.saturated = clip_x | clip_y;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] tag,
			input logic [31:0] exp_v, input logic [31:0] got_v);
		errors++;
		if (errors <= 10)
			$display("%0t: %s mismatch, tag %h: expected %h, got %h",
				$time, what, tag, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame.origin_x = '0;
			frame.origin_y = '0;
			frame.end_x = 32'(1) << (CW - 4);
			frame.end_y = '0;
			awaited.delete();
			errors = 0;
			pending = 0;
			n_degen = 0;
			n_clipped = 0;
		end else begin
			// register write snoop
			if (psel && penable && pwrite && pready) begin
				widx = tpfn_pkg::reg_idx_t'(paddr[tpfn_pkg::ADDR_W-1:tpfn_pkg::REG_SHIFT]);
				case (widx)
					tpfn_pkg::REG_ORIGIN_X: frame.origin_x = pwdata[CW-1:0];
					tpfn_pkg::REG_ORIGIN_Y: frame.origin_y = pwdata[CW-1:0];
					tpfn_pkg::REG_END_X:    frame.end_x = pwdata[CW-1:0];
					tpfn_pkg::REG_END_Y:    frame.end_y = pwdata[CW-1:0];
					default: ;
				endcase
			end

			// result beat against the oldest prediction
			if (result_valid && !result_stall) begin
				if (awaited.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result beat with tag %h and nothing awaited",
							$time, result.result_tag);
				end else begin
					want = awaited.pop_front();
					if (result.norm_x !== want.norm_x)
						flag_mismatch("norm_x", want.result_tag, want.norm_x, result.norm_x);
					if (result.norm_y !== want.norm_y)
						flag_mismatch("norm_y", want.result_tag, want.norm_y, result.norm_y);
					if (result.result_tag !== want.result_tag)
						flag_mismatch("result_tag", want.result_tag, 32'(want.result_tag),
							32'(result.result_tag));
					if (result.degenerate !== want.degenerate)
						flag_mismatch("degenerate", want.result_tag, 32'(want.degenerate),
							32'(result.degenerate));
					if (result.saturated !== want.saturated)
						flag_mismatch("saturated", want.result_tag, 32'(want.saturated),
							32'(result.saturated));
					if (want.degenerate)
						n_degen++;
					if (want.saturated)
						n_clipped++;
				end
			end

			// point beat: predict its result
			if (point_valid && !point_stall)
				awaited.insert(awaited.size(), map_point(frame, point));

			pending = awaited.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// top of the two-point frame normalizer bench: clock, reset, register writes,
// paced point beats, result stalls, watchdog and verdict
// depends on tpfn_pkg, two_point_frame_normalizer and tpfn_checker
`timescale 1ns / 100ps

module testbench;

	localparam logic [31:0] MAX_C = 32'h7fff_ffff;
	localparam logic [31:0] MIN_C = 32'h8000_0000;
	localparam logic [31:0] ONE_C = 32'h1000_0000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_FRAMES = 10;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [tpfn_pkg::ADDR_W-1:0]   paddr;
	logic [tpfn_pkg::APB_DW-1:0]   pwdata;
	logic [tpfn_pkg::APB_DW-1:0]   prdata;
	logic                          pready;
	logic                          point_valid;
	logic                          point_stall;
	tpfn_pkg::point_t              point;
	logic                          result_valid;
	logic                          result_stall;
	tpfn_pkg::result_t             result;

	int unsigned errors, pending, n_degen, n_clipped;
	int unsigned idle_cycles;
	int unsigned points_sent;
	int unsigned frames;
	int          burst_left;
	logic        hold_req;
	logic [31:0] cur_ox, cur_oy, cur_ex, cur_ey;

	two_point_frame_normalizer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	tpfn_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.errors      (errors),
		.pending     (pending),
		.n_degen     (n_degen),
		.n_clipped   (n_clipped)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog: cycles with no beat and no register access
	always @(posedge clk) begin
		if (!arst_n || (point_valid && !point_stall) || (result_valid && !result_stall) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// sign-extended random offset of random width, added to a base
	function automatic logic [31:0] near(input logic [31:0] base, input int max_w);
		int w;
		logic [31:0] off;
		w = $urandom_range(0, max_w);
		off = $urandom;
		if (w == 0)
			off = '0;
		else if (w < 32)
			off = $signed(off << (32 - w)) >>> (32 - w);
		return base + off;
	endfunction

	function automatic logic [31:0] corner();
		case ($urandom_range(0, 4))
			0: return MIN_C;
			1: return MAX_C;
			2: return '0;
			3: return '1;
			default: return 32'd1;
		endcase
	endfunction

	// point beat with burst and gap pacing
	task automatic offer(input logic [31:0] x, input logic [31:0] y, input logic [15:0] tag);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				point_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		point_valid <= 1'b1;
		point <= '{point_x: x, point_y: y, point_tag: tag};
		do @(posedge clk); while (point_stall);
		points_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		point_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input tpfn_pkg::reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tpfn_pkg::ADDR_W'(idx) << tpfn_pkg::REG_SHIFT;
		pwdata <= tpfn_pkg::APB_DW'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// new frame, only once the pipe is empty
	task automatic set_frame(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] ex, input logic [31:0] ey);
		wait_idle();
		write_reg(tpfn_pkg::REG_ORIGIN_X, ox);
		write_reg(tpfn_pkg::REG_ORIGIN_Y, oy);
		write_reg(tpfn_pkg::REG_END_X, ex);
		write_reg(tpfn_pkg::REG_END_Y, ey);
		cur_ox = ox;
		cur_oy = oy;
		cur_ex = ex;
		cur_ey = ey;
		frames++;
	endtask

	task automatic random_frame();
		logic [31:0] ox, oy;
		ox = $urandom;
		oy = $urandom;
		case ($urandom_range(0, 7))
			0: set_frame(ox, oy, ox, oy);
			1, 2: set_frame(corner(), corner(), corner(), corner());
			3, 4: set_frame(ox, oy, near(ox, 20), near(oy, 20));
			default: set_frame(ox, oy, $urandom, $urandom);
		endcase
	endtask

	// half the points near the frame ends, the rest anywhere or at the corners
	task automatic random_point();
		logic [31:0] x, y;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				if ($urandom_range(0, 1)) begin
					x = near(cur_ox, 32);
					y = near(cur_oy, 32);
				end else begin
					x = near(cur_ex, 32);
					y = near(cur_ey, 32);
				end
			end
			5, 6, 7: begin
				x = $urandom;
				y = $urandom;
			end
			default: begin
				x = corner();
				y = corner();
			end
		endcase
		offer(x, y, 16'($urandom));
	endtask

	// receiver stall patterns, plus one long hold-off on request
	initial begin
		int mode, mode_left, tick;
		logic held;
		result_stall = 1'b0;
		mode = 0;
		mode_left = 40;
		tick = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= ((tick % 5) < 2);
				endcase
				mode_left--;
				if (mode_left <= 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 150);
				end
			end
		end
	end

	// stimulus
	initial begin
		int n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		point_valid = 1'b0;
		point = '0;
		hold_req = 1'b0;
		points_sent = 0;
		frames = 1;
		burst_left = 0;
		cur_ox = '0;
		cur_oy = '0;
		cur_ex = ONE_C;
		cur_ey = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset frame: plain rescale, rounding ties both signs
		offer('0, '0, 16'h0000);
		offer(ONE_C, '0, 16'hffff);
		offer('0, ONE_C, 16'h0001);
		offer(MAX_C, MAX_C, 16'h8000);
		offer(MIN_C, MIN_C, 16'h7fff);
		offer(MAX_C, MIN_C, 16'h00ff);
		offer(32'd8, -32'sd8, 16'h0f0f);
		offer(-32'sd24, 32'd24, 16'hf0f0);
		offer(32'd7, 32'd9, 16'h1234);

		// origin and end coincide
		set_frame(32'h1234_5678, -32'sd5, 32'h1234_5678, -32'sd5);
		offer(MAX_C, MIN_C, 16'h0002);
		offer(32'h1234_5678, -32'sd5, 16'h0003);
		set_frame(MIN_C, MAX_C, MIN_C, MAX_C);
		offer('0, '0, 16'h0004);

		// one-lsb frame vectors: far points clip, the origin and end point do not
		set_frame('0, '0, 32'd1, '0);
		offer(MAX_C, MIN_C, 16'h0005);
		offer(MIN_C, MAX_C, 16'h0006);
		offer(32'd1, '0, 16'h0007);
		offer('0, '0, 16'h0008);
		set_frame(MIN_C, MIN_C, MIN_C, MIN_C + 32'd1);
		offer(MIN_C, MIN_C + 32'd1, 16'h0009);
		offer(MAX_C, MAX_C, 16'h000a);

		// widest frames, both directions
		set_frame(MIN_C, MIN_C, MAX_C, MAX_C);
		offer(MIN_C, MIN_C, 16'h000b);
		offer(MAX_C, MAX_C, 16'h000c);
		offer(MAX_C, MIN_C, 16'h000d);
		offer(MIN_C, MAX_C, 16'h000e);
		set_frame(MAX_C, MAX_C, MIN_C, MIN_C);
		offer('0, '0, 16'h000f);
		offer(MIN_C, MIN_C, 16'h0010);

		// random frames and points, one long receiver hold-off midway
		for (int f = 0; f < RANDOM_FRAMES; f++) begin
			random_frame();
			n = (f == 3) ? 90 : $urandom_range(30, 45);
			if (f == 3)
				hold_req = 1'b1;
			repeat (n) random_point();
		end

		wait_idle();
		repeat (60) @(negedge clk);
		$display("normalized %0d points over %0d frame settings: %0d degenerate, %0d clipped",
			points_sent, frames, n_degen, n_clipped);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
